### rtl/core/cba_pkg.sv
// shared types and constants of the compacting block allocator
// used by cba_cell, cba_ctrl, compacting_block_allocator and cba_checker
`default_nettype none

package cba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int DATA_W       = 16;
    // signed width of the tail space: buffer minus all headers minus payload
    localparam int SP_W         = $clog2((MAX_BLOCKS + 2) * HEADER_BYTES + 65536) + 1;
    localparam int OUT_TDATA_W  = 56;

    localparam logic [DATA_W-1:0] BUF_RESET  = 16'd4096;
    localparam logic [DATA_W-1:0] HANDLE_MAX = 16'hFFFF;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_RESP
    } t_state;

    // token handed from cell to cell during a free sweep
    typedef struct packed {
        logic              scan;
        logic              found;
        logic [DATA_W-1:0] fsize;
        logic [DATA_W-1:0] fprev;
        logic [DATA_W-1:0] pv;
    } t_link;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic              live;
    } t_bcast;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] handle;
        logic [DATA_W-1:0] size;
    } t_wr;

endpackage

`default_nettype wire

### rtl/core/compacting_block_allocator.sv
// top level of the compacting block allocator: sequencer plus a row of table cells
// depends on cba_pkg, cba_ctrl and cba_cell
//
// usage:
//   input words on s_axis: tuser = func (0 allocate, 1 free), tdata = amount
//   (payload bytes for allocate, handle for free). one result word per input
//   on m_axis: tuser = ok, tdata = handle, blocks_in_use, allocated_bytes,
//   largest_free, packed from bit 0 up.
//   i_cfg_wr_en / i_cfg_wr_data load the buffer size; write it only while idle.
// sequence:
//   an allocate passes ST_DECIDE and ST_RESP, then raises m_axis_tvalid from
//   the output register. a free of a nonzero handle sweeps a token once through
//   the row of 64 cells, one cell per cycle, before ST_RESP; handle 0 skips it.
//   one word is in flight at a time; s_axis_tready is high while idle, so a
//   new word is taken only after the last one has left ST_RESP.
// reset (synchronous, active low): table empty, buffer size 4096, no result
//   pending. the cell contents are not cleared, only the block count.
// stall: a finished result waits in the output register while the next
//   word is accepted; that word completes only once the register is taken.
`default_nettype none

module compacting_block_allocator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [15:0]                   s_axis_tdata,  // amount[15:0]
    input  wire                          s_axis_tuser,  // func
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // handle[15:0], blocks_in_use[22:16], allocated_bytes[38:23],
    // largest_free[54:39], zero pad[55]
    output logic [cba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tuser,  // ok
    input  wire                          i_cfg_wr_en,
    input  wire [15:0]                   i_cfg_wr_data
);
    import cba_pkg::*;

    t_link             links  [MAX_BLOCKS+1];
    logic [DATA_W-1:0] cell_h [MAX_BLOCKS];
    logic [DATA_W-1:0] cell_s [MAX_BLOCKS];
    t_bcast            bcast;
    t_wr               wr;

    cba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_link        (links[0]),
        .i_link_end    (links[MAX_BLOCKS]),
        .o_bcast       (bcast),
        .o_wr          (wr)
    );

    for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
        logic [DATA_W-1:0] up_h;
        logic [DATA_W-1:0] up_s;
        logic              sel;

        if (i == MAX_BLOCKS - 1) begin : g_top
            assign up_h = '0;
            assign up_s = '0;
        end else begin : g_mid
            assign up_h = cell_h[i+1];
            assign up_s = cell_s[i+1];
        end

        assign sel = wr.en && (wr.idx == IDX_W'(i));

        cba_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_link      (links[i]),
            .o_link      (links[i+1]),
            .i_bcast     (bcast),
            .i_wr_sel    (sel),
            .i_wr        (wr),
            .i_up_handle (up_h),
            .i_up_size   (up_s),
            .o_handle    (cell_h[i]),
            .o_size      (cell_s[i])
        );
    end

endmodule

`default_nettype wire

### rtl/core/cba_cell.sv
// one entry of the ordered block table: handle and payload size
// depends on cba_pkg; passes the sweep token to its upper neighbor
`default_nettype none

module cba_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  cba_pkg::t_link           i_link,
    output cba_pkg::t_link           o_link,
    input  cba_pkg::t_bcast          i_bcast,
    input  wire                      i_wr_sel,
    input  cba_pkg::t_wr             i_wr,
    input  wire [cba_pkg::DATA_W-1:0] i_up_handle,
    input  wire [cba_pkg::DATA_W-1:0] i_up_size,
    output logic [cba_pkg::DATA_W-1:0] o_handle,
    output logic [cba_pkg::DATA_W-1:0] o_size
);
    import cba_pkg::*;

    logic [DATA_W-1:0] r_handle;
    logic [DATA_W-1:0] r_size;
    t_link             r_link;
    t_link             n_link;
    logic              active;
    logic              match;
    logic              shift;

    always_comb begin
        active = i_link.scan & i_bcast.live;
        match  = active & ~i_link.found & (r_handle == i_bcast.key);
        shift  = active & (i_link.found | match);
        n_link = i_link;
        n_link.found = i_link.found | match;
        if (match) begin
            n_link.fsize = r_size;
            n_link.fprev = i_link.pv;
        end
        // remember the handle of the last live entry passed so far
        if (active) begin
            n_link.pv = r_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_sel) begin
            r_handle <= i_wr.handle;
            r_size   <= i_wr.size;
        end else if (shift) begin
            r_handle <= i_up_handle;
            r_size   <= i_up_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link   = r_link;
    assign o_handle = r_handle;
    assign o_size   = r_size;

endmodule

`default_nettype wire

### rtl/core/cba_ctrl.sv
// sequencer of the allocator: space check, alloc writes, free sweeps, result register
// depends on cba_pkg; drives the cell row through t_link, t_bcast and t_wr
`default_nettype none

module cba_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [15:0]                   s_axis_tdata,
    input  wire                          s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [cba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tuser,
    input  wire                          i_cfg_wr_en,
    input  wire [15:0]                   i_cfg_wr_data,
    output cba_pkg::t_link               o_link,
    input  cba_pkg::t_link               i_link_end,
    output cba_pkg::t_bcast              o_bcast,
    output cba_pkg::t_wr                 o_wr
);
    import cba_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    logic [DATA_W-1:0]        r_buf;
    logic [CNT_W-1:0]         r_total;
    logic [DATA_W-1:0]        r_used;
    logic [DATA_W-1:0]        r_last;
    logic                     r_func;
    logic [DATA_W-1:0]        r_key;
    logic [CNT_W-1:0]         r_step;
    logic                     r_res_ok;
    logic [DATA_W-1:0]        r_res_h;
    logic                     r_ovalid;
    logic                     r_ook;
    logic [OUT_TDATA_W-1:0]   r_odata;

    logic signed [SP_W-1:0]   space;
    logic [DATA_W-1:0]        base;
    logic [DATA_W-1:0]        new_handle;
    logic                     alloc_ok;
    logic [DATA_W-1:0]        largest;
    logic                     step_done;
    logic                     out_free;
    logic                     load_out;

    always_comb begin
        space = SP_W'(r_buf)
              - (SP_W'(r_total) + SP_W'(2)) * SP_W'(HEADER_BYTES)
              - SP_W'(r_used);
        base       = (r_total == '0) ? '0 : r_last;
        new_handle = base + 16'd1;
        alloc_ok   = (r_total != CNT_W'(MAX_BLOCKS)) && (base != HANDLE_MAX)
                   && (space >= $signed(SP_W'(r_key)));
        largest    = (space > 0) ? space[DATA_W-1:0] : '0;
        step_done  = (r_step == CNT_W'(MAX_BLOCKS));
        out_free   = ~r_ovalid | m_axis_tready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if ((r_func == FUNC_FREE) && (r_key != '0)) n_state = ST_SCAN;
                else n_state = ST_RESP;
            end
            ST_SCAN: begin
                if (step_done) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        load_out      = (r_state == ST_RESP) && out_free;
        o_link        = '0;
        o_link.scan   = (r_state == ST_SCAN) && (r_step == '0);
        o_bcast.key   = r_key;
        o_bcast.live  = (r_step < r_total);
        o_wr.en       = (r_state == ST_DECIDE) && (r_func == FUNC_ALLOC) && alloc_ok;
        o_wr.idx      = r_total[IDX_W-1:0];
        o_wr.handle   = new_handle;
        o_wr.size     = r_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_buf    <= BUF_RESET;
            r_total  <= '0;
            r_used   <= '0;
            r_last   <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_buf <= i_cfg_wr_data;
            end
            case (r_state)
                ST_DECIDE: begin
                    r_step <= '0;
                    if ((r_func == FUNC_ALLOC) && alloc_ok) begin
                        r_total <= r_total + CNT_W'(1);
                        r_used  <= r_used + r_key;
                        r_last  <= new_handle;
                    end
                end
                ST_SCAN: begin
                    if (!step_done) begin
                        r_step <= r_step + CNT_W'(1);
                    end else if (i_link_end.found) begin
                        r_total <= r_total - CNT_W'(1);
                        r_used  <= r_used - i_link_end.fsize;
                        // freeing the newest block makes its predecessor the newest
                        if (r_key == r_last) r_last <= i_link_end.fprev;
                    end
                end
                default: begin
                end
            endcase
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= s_axis_tuser;
            r_key  <= s_axis_tdata;
        end
        if (r_state == ST_DECIDE) begin
            if (r_func == FUNC_ALLOC) begin
                r_res_ok <= alloc_ok;
                r_res_h  <= alloc_ok ? new_handle : '0;
            end else begin
                r_res_ok <= 1'b0;
                r_res_h  <= '0;
            end
        end else if ((r_state == ST_SCAN) && step_done) begin
            r_res_ok <= i_link_end.found;
        end
        if (load_out) begin
            r_ook   <= r_res_ok;
            r_odata <= {1'b0, largest, r_used, 7'(r_total), r_res_h};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ook;

endmodule

`default_nettype wire

### rtl/core/cba_checker.sv
// port-level checks on compacting_block_allocator, attached by bind
// depends on cba_pkg and the top level's port list
`default_nettype none

module cba_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire [15:0]                   s_axis_tdata,
    input wire                          s_axis_tuser,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [cba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire                          m_axis_tuser,
    input wire                          i_cfg_wr_en,
    input wire [15:0]                   i_cfg_wr_data
);
    import cba_pkg::*;

    // after reset the block is ready and has nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("not idle after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result word changed while stalled");

    // a failed operation never reports a handle
    a_fail_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("handle on failed operation");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted a word while busy");

endmodule

bind compacting_block_allocator cba_checker u_cba_checker (.*);

`default_nettype wire
